>>> hdl/mdp_pkg.sv
// package with sizes and lane control type for the minimum dot product block
package mdp_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int VALUE_BITS = 16;
   localparam int SUM_BITS = 38;
   localparam int PCOUNT_BITS = 7;
   localparam int ADDR_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int PROD_BITS = 2 * VALUE_BITS;

   typedef enum logic [1:0] {
      WSEL_LOAD,
      WSEL_STEP,
      WSEL_TAIL
   } wsel_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      wsel_type             wsel;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
      logic                 carry_load;
      logic                 carry_step;
   } lane_ctl_type;
endpackage

>>> hdl/mdp_lane.sv
// one vector store with the carry register of the in-place bubble pass
module mdp_lane (
   input  logic                                  clock,
   input  mdp_pkg::lane_ctl_type                 ctl,
   input  logic                                  descend,
   input  logic signed [mdp_pkg::VALUE_BITS-1:0] load_value,
   output logic signed [mdp_pkg::VALUE_BITS-1:0] rdata
);
   logic signed [mdp_pkg::VALUE_BITS-1:0] mem [mdp_pkg::MAX_ENTRIES];
   logic signed [mdp_pkg::VALUE_BITS-1:0] rdata_ff;
   logic signed [mdp_pkg::VALUE_BITS-1:0] carry_ff;
   logic signed [mdp_pkg::VALUE_BITS-1:0] keep;
   logic signed [mdp_pkg::VALUE_BITS-1:0] pass_on;
   logic signed [mdp_pkg::VALUE_BITS-1:0] wdata;
   logic                                  carry_first;

   always_comb begin
      carry_first = descend ? (carry_ff > rdata_ff) : (carry_ff < rdata_ff);
      keep = carry_first ? carry_ff : rdata_ff;
      pass_on = carry_first ? rdata_ff : carry_ff;
      unique case (ctl.wsel)
         mdp_pkg::WSEL_LOAD: wdata = load_value;
         mdp_pkg::WSEL_STEP: wdata = keep;
         mdp_pkg::WSEL_TAIL: wdata = carry_ff;
         default:            wdata = load_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= wdata;
      end
      if (ctl.re) begin
         rdata_ff <= mem[ctl.raddr];
      end
      if (ctl.carry_load) begin
         carry_ff <= rdata_ff;
      end else if (ctl.carry_step) begin
         carry_ff <= pass_on;
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/min_dot_product_sorted_pairing.sv
// top level: pair store, in-place sort sequencer, multiply-accumulate and result register
//
// req_ channel: one beat per pair (first_value, second_value, last). Pairs are
// taken one per cycle while the block is collecting. A pair beyond 64 stored
// pairs is dropped and flags the result.
// On the beat with last high, req_stall rises and both stores are sorted in
// place by bubble passes: each pass walks the stored entries through one
// registered read port and one write port per store, n-1 passes after a
// state that primes the read port, n the number of stored pairs. A
// multiply-accumulate sweep follows, then the result register is loaded.
// rsp_ channel: one beat per vector (min_sum, pair_count, overflowed). The
// result register holds while rsp_stall is high; collection of the next
// vector already runs, and its result waits until the register is free.
// reset (synchronous, active high) empties the stores, clears the flag and
// drops any pending result. Stored values need no reset.
module min_dot_product_sorted_pairing (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [mdp_pkg::VALUE_BITS-1:0]    req_first_value,
   input  logic signed [mdp_pkg::VALUE_BITS-1:0]    req_second_value,
   input  logic                                     req_last,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mdp_pkg::SUM_BITS-1:0]      rsp_min_sum,
   output logic [mdp_pkg::PCOUNT_BITS-1:0]          rsp_pair_count,
   output logic                                     rsp_overflowed
);
   typedef enum logic [3:0] {
      S_IDLE, S_PASS, S_FIRST, S_STEP, S_TAIL, S_SUM, S_DR1, S_DR2, S_DR3, S_DONE
   } state_type;

   localparam int CB = mdp_pkg::CNT_BITS;
   localparam int AB = mdp_pkg::ADDR_BITS;

   state_type                              state_ff;
   logic [CB-1:0]                          count_ff, n_ff, j_ff, pass_ff, i_ff;
   logic                                   ovf_ff, ovf_res_ff;
   logic                                   rs_ff, pv_ff;
   logic signed [mdp_pkg::PROD_BITS-1:0]   prod_ff;
   logic signed [63:0]                     prod_wide;
   logic signed [mdp_pkg::SUM_BITS-1:0]    acc_ff;
   logic                                   rsp_valid_ff;
   logic signed [mdp_pkg::SUM_BITS-1:0]    rsp_sum_ff;
   logic [mdp_pkg::PCOUNT_BITS-1:0]        rsp_count_ff;
   logic                                   rsp_ovf_ff;
   logic                                   accept, full;
   logic [CB-1:0]                          n_in;
   mdp_pkg::lane_ctl_type                  ctl;
   logic signed [mdp_pkg::VALUE_BITS-1:0]  a_rd, b_rd;

   assign accept = req_valid && !req_stall;
   assign full = (count_ff == CB'(mdp_pkg::MAX_ENTRIES));
   assign n_in = full ? count_ff : count_ff + CB'(1);
   assign req_stall = (state_ff != S_IDLE);
   assign prod_wide = 64'(prod_ff);

   always_comb begin
      ctl = '0;
      ctl.wsel = mdp_pkg::WSEL_LOAD;
      unique case (state_ff)
         S_IDLE: begin
            ctl.we = accept && !full;
            ctl.waddr = count_ff[AB-1:0];
         end
         S_PASS: begin
            ctl.re = 1'b1;
            ctl.raddr = '0;
         end
         S_FIRST: begin
            ctl.re = 1'b1;
            ctl.raddr = AB'(1);
            ctl.carry_load = 1'b1;
         end
         S_STEP: begin
            ctl.we = 1'b1;
            ctl.waddr = j_ff[AB-1:0] - AB'(1);
            ctl.wsel = mdp_pkg::WSEL_STEP;
            ctl.carry_step = 1'b1;
            ctl.re = 1'b1;
            ctl.raddr = j_ff[AB-1:0] + AB'(1);
         end
         S_TAIL: begin
            ctl.we = 1'b1;
            ctl.waddr = j_ff[AB-1:0];
            ctl.wsel = mdp_pkg::WSEL_TAIL;
            ctl.re = 1'b1;
            ctl.raddr = '0;
         end
         S_SUM: begin
            ctl.re = 1'b1;
            ctl.raddr = i_ff[AB-1:0];
         end
         default: begin
            ctl.we = 1'b0;
         end
      endcase
   end

   mdp_lane u_first (
      .clock(clock), .ctl(ctl), .descend(1'b0),
      .load_value(req_first_value), .rdata(a_rd)
   );

   mdp_lane u_second (
      .clock(clock), .ctl(ctl), .descend(1'b1),
      .load_value(req_second_value), .rdata(b_rd)
   );

   always_ff @(posedge clock) begin
      prod_ff <= a_rd * b_rd;
      if (state_ff == S_PASS) begin
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + mdp_pkg::SUM_BITS'(prod_wide);
      end
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rs_ff <= 1'b0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rs_ff <= (state_ff == S_SUM);
         pv_ff <= rs_ff;
         if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_last) begin
                     count_ff <= '0;
                     ovf_ff <= 1'b0;
                     ovf_res_ff <= ovf_ff || full;
                     n_ff <= n_in;
                     pass_ff <= '0;
                     i_ff <= '0;
                     state_ff <= S_PASS;
                  end else if (full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CB'(1);
                  end
               end
            end
            S_PASS: begin
               state_ff <= (n_ff == CB'(1)) ? S_SUM : S_FIRST;
            end
            S_FIRST: begin
               j_ff <= CB'(1);
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (j_ff == n_ff - CB'(1)) begin
                  state_ff <= S_TAIL;
               end else begin
                  j_ff <= j_ff + CB'(1);
               end
            end
            S_TAIL: begin
               pass_ff <= pass_ff + CB'(1);
               state_ff <= (pass_ff + CB'(1) == n_ff - CB'(1)) ? S_SUM : S_FIRST;
            end
            S_SUM: begin
               if (i_ff == n_ff - CB'(1)) begin
                  state_ff <= S_DR1;
               end else begin
                  i_ff <= i_ff + CB'(1);
               end
            end
            S_DR1: state_ff <= S_DR2;
            S_DR2: state_ff <= S_DR3;
            S_DR3: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_sum_ff <= acc_ff;
                  rsp_count_ff <= mdp_pkg::PCOUNT_BITS'(n_ff);
                  rsp_ovf_ff <= ovf_res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_sum = rsp_sum_ff;
   assign rsp_pair_count = rsp_count_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(mdp_pkg::MAX_ENTRIES))
      else $error("store count beyond capacity");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> req_stall)
      else $error("last beat did not start the sort");

   a_sum_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SUM |-> i_ff < n_ff && n_ff != '0)
      else $error("sum sweep index out of range");
endmodule

>>> bench/mdp_checker.sv
// checker: predicts minimum dot products from accepted pairs and compares result beats
`timescale 1ns / 100ps
module mdp_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [mdp_pkg::VALUE_BITS-1:0] req_first_value,
   input  logic signed [mdp_pkg::VALUE_BITS-1:0] req_second_value,
   input  logic                                  req_last,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [mdp_pkg::SUM_BITS-1:0]   rsp_min_sum,
   input  logic [mdp_pkg::PCOUNT_BITS-1:0]       rsp_pair_count,
   input  logic                                  rsp_overflowed,
   output int                                    fail_count,
   output int                                    pending_count
);
   typedef struct {
      logic [mdp_pkg::SUM_BITS-1:0]    min_sum;
      logic [mdp_pkg::PCOUNT_BITS-1:0] pair_count;
      logic                            overflowed;
   } dot_result_type;

   longint         first_vals[mdp_pkg::MAX_ENTRIES];
   longint         second_vals[mdp_pkg::MAX_ENTRIES];
   int             held;
   logic           dropped;
   dot_result_type dot_expected[$];

   function automatic dot_result_type min_dot(input int n, input logic ovf);
      longint         a[mdp_pkg::MAX_ENTRIES];
      longint         b[mdp_pkg::MAX_ENTRIES];
      longint         t;
      longint         acc;
      dot_result_type r;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         a[i] = first_vals[i];
         b[i] = second_vals[i];
      end
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (a[j] < a[i]) begin
               t = a[i]; a[i] = a[j]; a[j] = t;
            end
            if (b[j] > b[i]) begin
               t = b[i]; b[i] = b[j]; b[j] = t;
            end
         end
      end
      for (int i = 0; i < n; i++) acc += a[i] * b[i];
      r.min_sum = acc[mdp_pkg::SUM_BITS-1:0];
      r.pair_count = n[mdp_pkg::PCOUNT_BITS-1:0];
      r.overflowed = ovf;
      return r;
   endfunction

   always @(posedge clock) begin
      dot_result_type e;
      if (reset) begin
         held <= 0;
         dropped <= 1'b0;
         fail_count <= 0;
         dot_expected.delete();
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            int  n;
            logic ovf;
            n = held;
            ovf = dropped;
            if (n < mdp_pkg::MAX_ENTRIES) begin
               first_vals[n] = req_first_value;
               second_vals[n] = req_second_value;
               n++;
            end else begin
               ovf = 1'b1;
            end
            if (req_last) begin
               dot_expected.insert(dot_expected.size(), min_dot(n, ovf));
               n = 0;
               ovf = 1'b0;
            end
            held <= n;
            dropped <= ovf;
         end
         if (rsp_valid && !rsp_stall) begin
            if (dot_expected.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: sum %0d count %0d ovf %0d",
                           rsp_min_sum, rsp_pair_count, rsp_overflowed);
               fail_count <= fail_count + 1;
            end else begin
               e = dot_expected.pop_front();
               if (e.min_sum !== rsp_min_sum || e.pair_count !== rsp_pair_count ||
                   e.overflowed !== rsp_overflowed) begin
                  if (fail_count < 10)
                     $display("mismatch: expected sum %0d count %0d ovf %0d, got %0d %0d %0d",
                              $signed(e.min_sum), e.pair_count, e.overflowed,
                              rsp_min_sum, rsp_pair_count, rsp_overflowed);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= dot_expected.size();
      end
   end
endmodule

>>> bench/testbench.sv
// testbench top: clock, reset, pair stimulus, result-side stalls, watchdog and verdict
`timescale 1ns / 100ps
module testbench;
   localparam int VB = mdp_pkg::VALUE_BITS;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [VB-1:0]                 req_first_value = '0;
   logic signed [VB-1:0]                 req_second_value = '0;
   logic                                 req_last = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [mdp_pkg::SUM_BITS-1:0]  rsp_min_sum;
   logic [mdp_pkg::PCOUNT_BITS-1:0]      rsp_pair_count;
   logic                                 rsp_overflowed;
   int                                   fail_count;
   int                                   pending_count;
   logic                                 quiet = 1'b0;
   logic                                 hold_off = 1'b0;
   int                                   idle_cycles = 0;

   localparam int WATCHDOG_LIMIT = 40000;

   always #2 clock = ~clock;

   min_dot_product_sorted_pairing uut (.*);

   mdp_checker u_checker (.*);

   task automatic send_pair(input logic [VB-1:0] f, input logic [VB-1:0] s,
                            input logic l);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_value <= f;
      req_second_value <= s;
      req_last <= l;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_vector(input int n);
      for (int i = 0; i < n; i++)
         send_pair(VB'($urandom), VB'($urandom), i == n - 1);
   endtask

   initial begin
      int n;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // extremes, single and small vectors
      send_pair(16'h8000, 16'h8000, 1'b1);
      send_pair(16'h7fff, 16'h7fff, 1'b1);
      send_pair(16'h8000, 16'h7fff, 1'b0);
      send_pair(16'h7fff, 16'h8000, 1'b1);
      send_pair(16'h0000, 16'hffff, 1'b0);
      send_pair(16'hffff, 16'h0000, 1'b0);
      send_pair(16'h8000, 16'h8000, 1'b1);
      send_pair(16'h0001, 16'h0001, 1'b0);
      send_pair(16'h0001, 16'h0001, 1'b1);
      // full store of extremes, then one dropped last pair
      for (int i = 0; i < mdp_pkg::MAX_ENTRIES; i++)
         send_pair(16'h8000, 16'h8000, i == mdp_pkg::MAX_ENTRIES - 1);
      for (int i = 0; i <= mdp_pkg::MAX_ENTRIES; i++)
         send_pair(16'h8000, 16'h7fff, i == mdp_pkg::MAX_ENTRIES);
      for (int k = 0; k < 35; k++) begin
         if (k == 10) hold_off <= 1'b1;
         if (k == 30) quiet <= 1'b1;
         case ($urandom_range(0, 29))
            0:       n = mdp_pkg::MAX_ENTRIES;
            1:       n = mdp_pkg::MAX_ENTRIES + $urandom_range(1, 4);
            default: n = $urandom_range(1, 8);
         endcase
         send_vector(n);
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      int len;
      bit long_done;
      long_done = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off && !long_done) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end
endmodule

>>> sim.f
hdl/mdp_pkg.sv
hdl/mdp_lane.sv
hdl/min_dot_product_sorted_pairing.sv
bench/mdp_checker.sv
bench/testbench.sv
